>>> design/kfs_pkg.sv
// ----------------------------------------------------------------------------
// Keyframe sampler package
// Shared sizes, codes, types and the controller state type for the
// keyframe vec3 sampler.
// ----------------------------------------------------------------------------
package kfs_pkg;

  localparam int MAX_KEYS = 64;
  localparam int AW       = $clog2(MAX_KEYS);
  localparam int CW       = $clog2(MAX_KEYS + 1);

  // Quotient bits retired per divider cycle.
  localparam int DIV_STEPS  = 2;
  localparam int DIV_CYCLES = 32 / DIV_STEPS;
  localparam int DIV_CW     = $clog2(DIV_CYCLES);

  localparam int LANES = 3;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic STATUS_NORMAL = 1'b0;
  localparam logic STATUS_EQUAL  = 1'b1;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef logic [AW-1:0] kfs_addr_t;
  typedef logic [CW-1:0] kfs_cnt_t;

  // Lane 0 is x, lane 1 is y, lane 2 is z.
  typedef logic [LANES-1:0][31:0] kfs_vec_t;

  typedef struct packed {
    logic        en;
    kfs_addr_t   addr;
    logic [31:0] key_time;
    kfs_vec_t    vec;
  } kfs_wr_t;

  typedef struct packed {
    logic        start;
    logic [31:0] t_sample;
    logic [31:0] t_early;
    logic [31:0] t_late;
  } kfs_div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] ratio;
  } kfs_div_rsp_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] ratio;
    kfs_vec_t           early;
    kfs_vec_t           late;
  } kfs_blend_req_t;

  typedef struct packed {
    logic     done;
    kfs_vec_t res;
  } kfs_blend_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EARLY,
    ST_LATE,
    ST_PREP,
    ST_DIVIDE,
    ST_BLEND,
    ST_FINISH
  } kfs_state_t;

endpackage

>>> design/kfs_key_store.sv
// ----------------------------------------------------------------------------
// Key store
// Two synchronous memories, one for key times and one for the packed xyz
// values. One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module kfs_key_store (
  input  logic               clk,
  input  kfs_pkg::kfs_wr_t   wr,
  input  kfs_pkg::kfs_addr_t rd_addr,
  output logic [31:0]        rd_time,
  output kfs_pkg::kfs_vec_t  rd_vec
);

  logic [31:0]       time_mem [kfs_pkg::MAX_KEYS];
  kfs_pkg::kfs_vec_t val_mem  [kfs_pkg::MAX_KEYS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      time_mem[wr.addr] <= wr.key_time;
      val_mem[wr.addr]  <= wr.vec;
    end
    rd_time <= time_mem[rd_addr];
    rd_vec  <= val_mem[rd_addr];
  end

endmodule

>>> design/kfs_divider.sv
// ----------------------------------------------------------------------------
// Ratio divider
// Computes the saturated Q16.16 ratio (t - te) / (tl - te) with a restoring
// divider on magnitudes, DIV_STEPS quotient bits per cycle.
// ----------------------------------------------------------------------------
module kfs_divider (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kfs_pkg::kfs_div_req_t req,
  output kfs_pkg::kfs_div_rsp_t rsp
);

  logic                       run_r;
  logic                       fin_r;
  logic                       done_r;
  logic                       ovf_r;
  logic                       neg_r;
  logic [kfs_pkg::DIV_CW-1:0] cnt_r;
  logic [31:0]                rem_r;
  logic [31:0]                quo_r;
  logic [31:0]                den_r;
  logic signed [31:0]         ratio_r;

  logic        num_pos;
  logic        den_pos;
  logic [31:0] num_mag;
  logic [31:0] den_mag;
  logic [32:0] part_s;
  logic [31:0] rem_s;
  logic [31:0] quo_s;
  logic [31:0] ratio_s;

  // Magnitudes of the two differences, picked from parallel subtractions.
  always_comb begin
    num_pos = req.t_sample >= req.t_early;
    den_pos = req.t_late >= req.t_early;
    num_mag = num_pos ? (req.t_sample - req.t_early) : (req.t_early - req.t_sample);
    den_mag = den_pos ? (req.t_late - req.t_early) : (req.t_early - req.t_late);
  end

  // The dividend is |num| << 16; its upper 32 bits start in the remainder,
  // the rest shift in from the quotient register as it fills.
  always_comb begin
    rem_s  = rem_r;
    quo_s  = quo_r;
    part_s = '0;
    for (int i = 0; i < kfs_pkg::DIV_STEPS; i++) begin
      part_s = {rem_s, quo_s[31]};
      quo_s  = {quo_s[30:0], 1'b0};
      if (part_s >= {1'b0, den_r}) begin
        part_s   = part_s - {1'b0, den_r};
        quo_s[0] = 1'b1;
      end
      rem_s = part_s[31:0];
    end
  end

  // A starting remainder at or above the divisor means the quotient needs
  // more than 32 bits, which saturates in any case.
  always_comb begin
    if (ovf_r) begin
      ratio_s = neg_r ? kfs_pkg::Q_MIN : kfs_pkg::Q_MAX;
    end else if (neg_r) begin
      ratio_s = (quo_r > kfs_pkg::Q_MIN) ? kfs_pkg::Q_MIN : (~quo_r + 32'd1);
    end else begin
      ratio_s = quo_r[31] ? kfs_pkg::Q_MAX : quo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= !req.start && run_r
                && (cnt_r == kfs_pkg::DIV_CW'(kfs_pkg::DIV_CYCLES - 1));
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == kfs_pkg::DIV_CW'(kfs_pkg::DIV_CYCLES - 1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= {16'b0, num_mag[31:16]};
      quo_r <= {num_mag[15:0], 16'b0};
      den_r <= den_mag;
      neg_r <= num_pos ^ den_pos;
    end else if (run_r) begin
      rem_r <= rem_s;
      quo_r <= quo_s;
      if (cnt_r == '0) begin
        ovf_r <= rem_r >= den_r;
      end
    end
    if (fin_r) begin
      ratio_r <= ratio_s;
    end
  end

  assign rsp.done  = done_r;
  assign rsp.ratio = ratio_r;

endmodule

>>> design/kfs_blend.sv
// ----------------------------------------------------------------------------
// Lane blender
// Forms early + floor(ratio * (late - early) / 65536) for x, y and z with one
// shared multiplier, one lane per cycle, and saturates each to 32 bits.
// ----------------------------------------------------------------------------
module kfs_blend (
  input  logic                    clk,
  input  logic                    rst_n,
  input  kfs_pkg::kfs_blend_req_t req,
  output kfs_pkg::kfs_blend_rsp_t rsp
);

  localparam logic [2:0] STEP_LAST = 3'd4;

  logic               run_r;
  logic               done_r;
  logic [2:0]         step_r;
  logic signed [31:0] ratio_r;
  logic signed [32:0] diff_r [kfs_pkg::LANES];
  logic signed [64:0] prod_r;
  kfs_pkg::kfs_vec_t  res_r;

  logic [1:0]         mul_lane;
  logic [1:0]         add_lane;
  logic [31:0]        early_s;
  logic signed [64:0] shifted_s;
  logic [49:0]        sum_s;
  logic [31:0]        sat_s;

  // Step 0 forms the differences, steps 1 to 3 multiply, steps 2 to 4 add.
  always_comb begin
    mul_lane  = 2'(step_r - 3'd1);
    add_lane  = 2'(step_r - 3'd2);
    early_s   = req.early[add_lane];
    shifted_s = prod_r >>> 16;
    sum_s     = {{18{early_s[31]}}, early_s} + shifted_s[49:0];
    if (!sum_s[49] && (|sum_s[48:31])) begin
      sat_s = kfs_pkg::Q_MAX;
    end else if (sum_s[49] && !(&sum_s[48:31])) begin
      sat_s = kfs_pkg::Q_MIN;
    end else begin
      sat_s = sum_s[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= !req.start && run_r && (step_r == STEP_LAST);
      if (req.start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == STEP_LAST) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      ratio_r <= req.ratio;
    end
    if (run_r) begin
      if (step_r == 3'd0) begin
        for (int l = 0; l < kfs_pkg::LANES; l++) begin
          diff_r[l] <= {req.late[l][31], req.late[l]} - {req.early[l][31], req.early[l]};
        end
      end
      if (step_r >= 3'd1 && step_r <= 3'd3) begin
        prod_r <= ratio_r * diff_r[mul_lane];
      end
      if (step_r >= 3'd2 && step_r <= STEP_LAST) begin
        res_r[add_lane] <= sat_s;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

>>> design/keyframe_vec3_sampler.sv
// ----------------------------------------------------------------------------
// Keyframe vec3 sampler
// Holds a track of keyframes and returns a linearly interpolated, saturated
// xyz value for each sample request.
// ----------------------------------------------------------------------------
// A load request writes one keyframe in the cycle it is accepted and gives no
// result. A sample request holds the input until it is done: the key search
// takes up to six halving steps for a 64-key track, since the time memory
// serves one read per cycle; then the early and late keys are read, the
// divider is set up and retires two ratio bits a cycle, the blender's one
// multiplier serves x, y and z in turn, and the finish state hands over the
// result once the output register is free. With one key the result goes to
// the finish state right after the early key read; when the two keys have
// equal times it skips the divider and blender. A finished result waits in
// the output register while the next request is taken.
module keyframe_vec3_sampler (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic [5:0]         in_key_index,
  input  logic [31:0]        in_key_time,
  input  logic signed [31:0] in_key_x,
  input  logic signed [31:0] in_key_y,
  input  logic signed [31:0] in_key_z,
  input  logic [31:0]        in_sample_time,

  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [5:0]         out_early_slot,
  output logic               out_status
);

  localparam int CW = kfs_pkg::CW;
  localparam int AW = kfs_pkg::AW;

  kfs_pkg::kfs_state_t state_r, state_nxt;

  logic [6:0]         key_count_r;
  kfs_pkg::kfs_cnt_t  count;
  kfs_pkg::kfs_addr_t base_r;
  kfs_pkg::kfs_cnt_t  n_r;
  logic               single_r;
  logic [31:0]        t_r;
  logic [31:0]        t_e_r;
  logic [31:0]        t_l_r;
  kfs_pkg::kfs_vec_t  v_e_r;
  kfs_pkg::kfs_vec_t  v_l_r;
  kfs_pkg::kfs_vec_t  res_r;
  logic               status_r;

  logic               out_valid_r;
  logic [31:0]        out_x_r;
  logic [31:0]        out_y_r;
  logic [31:0]        out_z_r;
  logic [5:0]         out_slot_r;
  logic               out_status_r;

  kfs_pkg::kfs_cnt_t  half;
  kfs_pkg::kfs_addr_t base_s;
  kfs_pkg::kfs_cnt_t  n_s;
  logic               sample_acc;
  logic               out_free;
  logic               times_equal;

  kfs_pkg::kfs_wr_t         wr;
  kfs_pkg::kfs_addr_t       rd_addr;
  logic [31:0]              rd_time;
  kfs_pkg::kfs_vec_t        rd_vec;
  kfs_pkg::kfs_div_req_t    div_req;
  kfs_pkg::kfs_div_rsp_t    div_rsp;
  kfs_pkg::kfs_blend_req_t  blend_req;
  kfs_pkg::kfs_blend_rsp_t  blend_rsp;

  kfs_key_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_time (rd_time),
    .rd_vec  (rd_vec)
  );

  kfs_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  kfs_blend u_blend (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (blend_req),
    .rsp   (blend_rsp)
  );

  // Key count in use, clamped to one through the track size.
  always_comb begin
    if (key_count_r == '0) begin
      count = CW'(1);
    end else if (32'(key_count_r) > 32'(kfs_pkg::MAX_KEYS)) begin
      count = CW'(kfs_pkg::MAX_KEYS);
    end else begin
      count = CW'(key_count_r);
    end
  end

  // One halving step: rd_time holds the key at base + n/2.
  always_comb begin
    half = n_r >> 1;
    if (t_r < rd_time) begin
      base_s = base_r;
      n_s    = half + CW'(1);
    end else begin
      base_s = base_r + AW'(half);
      n_s    = n_r - half;
    end
  end

  assign sample_acc  = (state_r == kfs_pkg::ST_IDLE) && in_valid
                       && (in_operation == kfs_pkg::OP_SAMPLE);
  assign out_free    = !out_valid_r || !out_stall;
  assign times_equal = (t_l_r == t_e_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kfs_pkg::ST_IDLE: begin
        if (sample_acc) begin
          state_nxt = (count > CW'(2)) ? kfs_pkg::ST_SEARCH : kfs_pkg::ST_EARLY;
        end
      end
      kfs_pkg::ST_SEARCH: begin
        if (n_s <= CW'(2)) begin
          state_nxt = kfs_pkg::ST_EARLY;
        end
      end
      kfs_pkg::ST_EARLY:  state_nxt = single_r ? kfs_pkg::ST_FINISH : kfs_pkg::ST_LATE;
      kfs_pkg::ST_LATE:   state_nxt = kfs_pkg::ST_PREP;
      kfs_pkg::ST_PREP:   state_nxt = times_equal ? kfs_pkg::ST_FINISH : kfs_pkg::ST_DIVIDE;
      kfs_pkg::ST_DIVIDE: begin
        if (div_rsp.done) begin
          state_nxt = kfs_pkg::ST_BLEND;
        end
      end
      kfs_pkg::ST_BLEND: begin
        if (blend_rsp.done) begin
          state_nxt = kfs_pkg::ST_FINISH;
        end
      end
      kfs_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = kfs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = kfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    rd_addr  = base_r;

    wr.en       = 1'b0;
    wr.addr     = AW'(in_key_index);
    wr.key_time = in_key_time;
    wr.vec      = {in_key_z, in_key_y, in_key_x};

    div_req.start    = 1'b0;
    div_req.t_sample = t_r;
    div_req.t_early  = t_e_r;
    div_req.t_late   = t_l_r;

    blend_req.start = 1'b0;
    blend_req.ratio = div_rsp.ratio;
    blend_req.early = v_e_r;
    blend_req.late  = v_l_r;

    unique case (state_r)
      kfs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        wr.en    = in_valid && (in_operation == kfs_pkg::OP_LOAD)
                   && (32'(in_key_index) < 32'(kfs_pkg::MAX_KEYS));
        rd_addr  = (count > CW'(2)) ? AW'(count >> 1) : '0;
      end
      kfs_pkg::ST_SEARCH: begin
        rd_addr = (n_s > CW'(2)) ? (base_s + AW'(n_s >> 1)) : base_s;
      end
      kfs_pkg::ST_EARLY: begin
        rd_addr = base_r + AW'(1);
      end
      kfs_pkg::ST_PREP: begin
        div_req.start = !times_equal;
      end
      kfs_pkg::ST_DIVIDE: begin
        blend_req.start = div_rsp.done;
      end
      kfs_pkg::ST_LATE,
      kfs_pkg::ST_BLEND,
      kfs_pkg::ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kfs_pkg::ST_IDLE;
      key_count_r <= 7'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        key_count_r <= cfg_wdata;
      end
      if (state_r == kfs_pkg::ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      kfs_pkg::ST_IDLE: begin
        if (sample_acc) begin
          base_r   <= '0;
          n_r      <= count;
          single_r <= (count == CW'(1));
          t_r      <= in_sample_time;
        end
      end
      kfs_pkg::ST_SEARCH: begin
        base_r <= base_s;
        n_r    <= n_s;
      end
      kfs_pkg::ST_EARLY: begin
        t_e_r    <= rd_time;
        v_e_r    <= rd_vec;
        res_r    <= rd_vec;
        status_r <= kfs_pkg::STATUS_NORMAL;
      end
      kfs_pkg::ST_LATE: begin
        t_l_r <= rd_time;
        v_l_r <= rd_vec;
      end
      kfs_pkg::ST_PREP: begin
        if (times_equal) begin
          status_r <= kfs_pkg::STATUS_EQUAL;
        end
      end
      kfs_pkg::ST_BLEND: begin
        if (blend_rsp.done) begin
          res_r <= blend_rsp.res;
        end
      end
      kfs_pkg::ST_DIVIDE,
      kfs_pkg::ST_FINISH: begin
      end
      default: begin
      end
    endcase

    if (state_r == kfs_pkg::ST_FINISH && out_free) begin
      out_x_r      <= res_r[0];
      out_y_r      <= res_r[1];
      out_z_r      <= res_r[2];
      out_slot_r   <= 6'(base_r);
      out_status_r <= status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_z          = out_z_r;
  assign out_early_slot = out_slot_r;
  assign out_status     = out_status_r;

  a_div_done_in_divide : assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == kfs_pkg::ST_DIVIDE)
    else $error("divider finished outside the divide phase");

  a_blend_done_in_blend : assert property (@(posedge clk) disable iff (!rst_n)
    blend_rsp.done |-> state_r == kfs_pkg::ST_BLEND)
    else $error("blender finished outside the blend phase");

  a_search_span : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == kfs_pkg::ST_SEARCH |-> n_r > CW'(2))
    else $error("search step taken with two or fewer keys left");

  a_finish_delivers : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kfs_pkg::ST_FINISH && out_free) |=> out_valid)
    else $error("finished sample did not reach the output register");

endmodule
